/* sv/smbus_pec_pkg.sv */
// types, opcodes and crc-8 fold function for the smbus pec checker
package smbus_pec_pkg;

    localparam int CRC_W = 8;

    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [1:0]       opcode_t;

    localparam opcode_t OP_HEADER  = 2'd0;
    localparam opcode_t OP_PAYLOAD = 2'd1;
    localparam opcode_t OP_FINISH  = 2'd2;

    localparam crc_t PEC_POLY = 8'h07;
    localparam crc_t PEC_INIT = 8'h00;

    typedef struct packed {
        opcode_t    opcode;
        logic [6:0] target_address;
        logic [7:0] command_code;
        logic       read_transfer;
        logic       block_transfer;
        logic [7:0] byte_count;
        logic [7:0] payload_byte;
        logic [7:0] received_pec;
    } pec_item_t;

    // one byte into the crc, msb first; unrolls to an xor network
    function automatic crc_t crc8_fold(input crc_t crc, input logic [7:0] data);
        crc_t c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ PEC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/smbus_pec_crc8_checker_top.sv */
// smbus pec (crc-8, poly 0x07) generator and checker with stream ports
//
// input beats carry one command each, selected by s_axis_tuser[1:0]:
//   header  - restarts the crc over address+w, command, address+r when
//             reading, and the length byte on block transfers
//   payload - folds one data byte into the running crc
//   finish  - compares received_pec with the running crc, crc unchanged
//   the unused code passes the crc through with both flags low
// every input beat gives exactly one output beat: m_axis_tdata is the crc
// after that beat, m_axis_tuser flags the compare result on finish beats.
// an input beat passes the input register, then the fold network into the
// result register, before its output beat is valid. throughput is one beat
// per cycle while the receiver takes results; the header's four chained
// byte folds are the longest path between those registers.
// reset clears the running crc and empties both register stages.
// when the receiver stalls, the result register holds and an empty input
// register takes one more beat before s_axis_tready drops.
module smbus_pec_crc8_checker_top
    import smbus_pec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target_address[6:0], command_code[14:7], byte_count[22:15],
    // payload_byte[30:23], received_pec[38:31], zero pad [39]
    input  logic [39:0] s_axis_tdata,
    // opcode[1:0], read_transfer[2], block_transfer[3]
    input  logic [3:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // crc_value[7:0]
    output logic [7:0]  m_axis_tdata,
    // pec_match[0], check_done[1]
    output logic [1:0]  m_axis_tuser
);

    logic      in_valid_reg;
    pec_item_t in_item_reg;
    crc_t      crc_reg;
    crc_t      crc_next;
    logic      m_valid_reg;
    crc_t      m_crc_reg;
    logic      m_match_reg;
    logic      m_done_reg;
    logic      match_next;
    logic      done_next;

    logic      advance;
    logic      s_accept;
    pec_item_t s_item;

    crc_t      hdr_c1;
    crc_t      hdr_c2;
    crc_t      hdr_c3;
    crc_t      hdr_c4;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s_item.opcode         = s_axis_tuser[1:0];
        s_item.read_transfer  = s_axis_tuser[2];
        s_item.block_transfer = s_axis_tuser[3];
        s_item.target_address = s_axis_tdata[6:0];
        s_item.command_code   = s_axis_tdata[14:7];
        s_item.byte_count     = s_axis_tdata[22:15];
        s_item.payload_byte   = s_axis_tdata[30:23];
        s_item.received_pec   = s_axis_tdata[38:31];
    end

    // header: address with write bit, command, optional read address and length
    always_comb begin
        hdr_c1 = crc8_fold(PEC_INIT, {in_item_reg.target_address, 1'b0});
        hdr_c2 = crc8_fold(hdr_c1, in_item_reg.command_code);
        hdr_c3 = in_item_reg.read_transfer
               ? crc8_fold(hdr_c2, {in_item_reg.target_address, 1'b1}) : hdr_c2;
        hdr_c4 = in_item_reg.block_transfer
               ? crc8_fold(hdr_c3, in_item_reg.byte_count) : hdr_c3;
    end

    always_comb begin
        crc_next   = crc_reg;
        match_next = 1'b0;
        done_next  = 1'b0;
        unique case (in_item_reg.opcode)
            OP_HEADER: begin
                crc_next = hdr_c4;
            end
            OP_PAYLOAD: begin
                crc_next = crc8_fold(crc_reg, in_item_reg.payload_byte);
            end
            OP_FINISH: begin
                done_next  = 1'b1;
                match_next = (in_item_reg.received_pec == crc_reg);
            end
            default: begin
                crc_next = crc_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            crc_reg      <= PEC_INIT;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    crc_reg <= crc_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (advance && in_valid_reg) begin
            m_crc_reg   <= crc_next;
            m_match_reg <= match_next;
            m_done_reg  <= done_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_crc_reg;
    assign m_axis_tuser  = {m_done_reg, m_match_reg};

`ifndef NO_ASSERTIONS
    // the shown crc is always the running crc, since both load together
    a_out_crc_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_crc_reg == crc_reg)
        else $error("output crc differs from running crc");

    // a match can only be flagged on a finish result
    a_match_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_done_reg |-> !m_match_reg)
        else $error("pec_match set without check_done");

    // finish beats leave the running crc alone
    a_finish_keeps_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg && in_item_reg.opcode == OP_FINISH
        |=> crc_reg == $past(crc_reg))
        else $error("finish beat changed the crc");

    // a beat leaving the input register lands in the result register
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg |=> m_valid_reg)
        else $error("beat lost between stages");
`endif

endmodule

/* bench/smbus_pec_crc8_checker_top_tb.sv */
`timescale 1ns / 1ps
// self-checking stream bench for the smbus pec crc-8 checker: directed and random beats, scoreboard on crc and flags
module smbus_pec_crc8_checker_top_tb
    import smbus_pec_pkg::*;
();

    localparam opcode_t OP_IDLE        = 2'd3;  // unused code, crc passes through
    localparam int      TOTAL_ITEMS    = 760;
    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      DRAIN_CYCLES   = 12;
    localparam int      HOLDOFF_AT     = 600;
    localparam int      HOLDOFF_LEN    = 64;

    typedef struct packed {
        crc_t crc_value;
        logic pec_match;
        logic check_done;
    } pec_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    pec_item_t   pending_items[$];
    pec_result_t expected_crcs[$];
    pec_item_t   item_on_bus;
    crc_t        tracked_crc = PEC_INIT;   // crc as the block should hold it
    crc_t        gen_crc = PEC_INIT;       // crc seen by the stimulus builder
    int          items_queued = 0;
    int          items_accepted = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          rx_holdoff = 0;
    bit          holdoff_done = 1'b0;

    smbus_pec_crc8_checker_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shift the byte in one bit at a time, msb first
    function automatic crc_t crc8_shift_in(input crc_t crc, input logic [7:0] data);
        crc_t r;
        logic fb;
        r = crc;
        for (int b = 7; b >= 0; b--) begin
            fb = r[7] ^ data[b];
            r  = {r[6:0], 1'b0} ^ (fb ? PEC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic pec_result_t pec_step(input crc_t crc_now, input pec_item_t it);
        pec_result_t res;
        crc_t        c;
        res = '0;
        c   = crc_now;
        case (it.opcode)
            OP_HEADER: begin
                c = crc8_shift_in(PEC_INIT, {it.target_address, 1'b0});
                c = crc8_shift_in(c, it.command_code);
                if (it.read_transfer) c = crc8_shift_in(c, {it.target_address, 1'b1});
                if (it.block_transfer) c = crc8_shift_in(c, it.byte_count);
            end
            OP_PAYLOAD: c = crc8_shift_in(c, it.payload_byte);
            OP_FINISH: begin
                res.check_done = 1'b1;
                res.pec_match  = (it.received_pec == c);
            end
            default: ;
        endcase
        res.crc_value = c;
        return res;
    endfunction

    function automatic pec_item_t random_item(input opcode_t op);
        pec_item_t   it;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(pec_item_t)-1:0];
        it.opcode = op;
        return it;
    endfunction

    task automatic queue_item(input pec_item_t it);
        pec_result_t r;
        pending_items.push_back(it);
        r = pec_step(gen_crc, it);
        gen_crc = r.crc_value;
        items_queued++;
    endtask

    task automatic queue_finish(input bit want_match);
        pec_item_t it;
        it = random_item(OP_FINISH);
        if (want_match) it.received_pec = gen_crc;
        queue_item(it);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("pec check error at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // idle percentages: receiver-heavy stalls, then sender-heavy, then none
    function automatic int sender_idle_pct();
        if (items_accepted < 250) return 29;
        if (items_accepted < 500) return 73;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_accepted < 250) return 73;
        if (items_accepted < 500) return 29;
        return 0;
    endfunction

    always @(posedge aclk) begin : driver
        pec_item_t   nxt;
        pec_result_t res;
        bit          offer;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                res = pec_step(tracked_crc, item_on_bus);
                tracked_crc = res.crc_value;
                expected_crcs.push_back(res);
                items_accepted <= items_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = (pending_items.size() != 0) &&
                        ($urandom_range(99) >= sender_idle_pct());
                if (offer) begin
                    nxt = pending_items.pop_front();
                    item_on_bus <= nxt;
                    s_axis_tdata <= {1'b0, nxt.received_pec, nxt.payload_byte,
                                     nxt.byte_count, nxt.command_code, nxt.target_address};
                    s_axis_tuser <= {nxt.block_transfer, nxt.read_transfer, nxt.opcode};
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        pec_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_crcs.size() == 0) begin
                    report_mismatch("result beat with nothing pending", int'(m_axis_tdata), 0);
                end else begin
                    want = expected_crcs.pop_front();
                    if (m_axis_tdata !== want.crc_value)
                        report_mismatch("crc_value", int'(m_axis_tdata),
                                        int'(want.crc_value));
                    if (m_axis_tuser[0] !== want.pec_match)
                        report_mismatch("pec_match", int'(m_axis_tuser[0]),
                                        int'(want.pec_match));
                    if (m_axis_tuser[1] !== want.check_done)
                        report_mismatch("check_done", int'(m_axis_tuser[1]),
                                        int'(want.check_done));
                end
            end
            m_axis_tready <= (rx_holdoff == 0) && ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // long receiver stall so the pipeline fills and input backs up
    always @(posedge aclk) begin : holdoff
        if (!aresetn) begin
            rx_holdoff <= 0;
        end else if (rx_holdoff != 0) begin
            rx_holdoff <= rx_holdoff - 1;
        end else if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
            rx_holdoff   <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        pec_item_t it;
        int        n_payload;

        // payload with no header yet folds into the reset crc
        it = random_item(OP_PAYLOAD);
        it.payload_byte = 8'hA5;
        queue_item(it);
        queue_finish(1'b1);

        it = '0;
        it.opcode = OP_HEADER;
        queue_item(it);
        queue_finish(1'b1);

        it = '1;
        it.opcode = OP_HEADER;
        queue_item(it);
        it = random_item(OP_PAYLOAD);
        it.payload_byte = 8'h00;
        queue_item(it);
        it = random_item(OP_PAYLOAD);
        it.payload_byte = 8'hFF;
        queue_item(it);
        it = random_item(OP_FINISH);
        it.received_pec = ~gen_crc;
        queue_item(it);
        // repeated finish compares the same crc again
        queue_finish(1'b1);
        queue_item(random_item(OP_IDLE));
        queue_finish(1'b1);

        it = random_item(OP_HEADER);
        it.read_transfer  = 1'b1;
        it.block_transfer = 1'b0;
        queue_item(it);
        queue_finish(1'b1);
        it = random_item(OP_HEADER);
        it.read_transfer  = 1'b0;
        it.block_transfer = 1'b1;
        it.byte_count     = 8'h00;
        queue_item(it);
        it = random_item(OP_PAYLOAD);
        it.payload_byte = 8'hFF;
        queue_item(it);
        queue_finish(1'b1);
        it = '1;
        it.opcode = OP_IDLE;
        queue_item(it);
        it = '1;
        it.opcode = OP_FINISH;
        queue_item(it);
        it = '0;
        it.opcode = OP_PAYLOAD;
        queue_item(it);
        queue_finish(1'b0);

        // mostly whole transactions, some stray and broken beats
        while (items_queued < TOTAL_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                it = random_item(opcode_t'($urandom_range(3)));
                if (it.opcode == OP_FINISH && $urandom_range(1)) it.received_pec = gen_crc;
                queue_item(it);
            end else begin
                queue_item(random_item(OP_HEADER));
                n_payload = $urandom_range(8);
                for (int k = 0; k < n_payload; k++) queue_item(random_item(OP_PAYLOAD));
                queue_finish($urandom_range(3) != 0);
                if ($urandom_range(7) == 0) queue_finish($urandom_range(1) != 0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < items_queued) @(posedge aclk);
        while (expected_crcs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_crcs.size() != 0)
            report_mismatch("results never delivered", expected_crcs.size(), 0);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
